[design/lbb_pkg.sv]
// Package for the label bounding box block.
// Holds the item and table entry types, register addresses and size constants.
// Used by every module of the block but lbb_ram; depends on nothing.
package lbb_pkg;

  localparam int MAX_REGIONS_DEFAULT = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_WIDTH = 2048;

  localparam int LABEL_W = 11;
  localparam int CFG_W = 11;
  localparam int X_W = 12;
  localparam int Y_W = 11;
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int COL_W = $clog2(MAX_WIDTH);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] COLUMN_HEIGHT_RESET = CFG_W'(480);
  localparam logic [CFG_W-1:0] REGION_COUNT_RESET = CFG_W'(1024);

  // Register select is bit 2 of the byte address.
  localparam logic REG_COLUMN_HEIGHT = 1'b0;
  localparam logic REG_REGION_COUNT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [LABEL_W-1:0] region_label;
    logic               end_of_image;
  } req_t;

  typedef struct packed {
    logic           label_error;
    logic           present;
    logic [X_W-1:0] x_min;
    logic [X_W-1:0] x_max;
    logic [Y_W-1:0] y_min;
    logic [Y_W-1:0] y_max;
  } res_t;

  typedef struct packed {
    logic           present;
    logic [X_W-1:0] x_min;
    logic [X_W-1:0] x_max;
    logic [Y_W-1:0] y_min;
    logic [Y_W-1:0] y_max;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] column_height;
    logic [CFG_W-1:0] region_count;
  } cfg_t;

  // Control carried with an item from the table read to the write-back.
  typedef struct packed {
    logic           mode;
    logic           label_error;
    logic           update;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } stage_t;

endpackage

[design/label_bounding_boxes_top.sv]
// Top level of the label bounding box block: box table RAM, read-modify-write pipeline.
// Depends on lbb_pkg, lbb_ram, lbb_cfg, lbb_pos and lbb_merge.
//
// Items arrive on the req channel and results leave on the res channel, both
// valid/ready. A pixel item (mode 0) carries a label in column-major scan order
// and updates that region's box; its result carries only the error flag. A read
// item (mode 1) returns one region's box and clears the entry.
// Every accepted item gives exactly one result item. One item is accepted per
// cycle while the receiver does not stall: the table is read in the cycle of
// acceptance and written back as the item leaves the write-back stage, with a
// forwarding register for an item that follows one to the same entry.
// After reset the block clears the table, one entry per cycle, with req_ready
// low; configuration writes are taken meanwhile.
// When the receiver stalls, one result waits in the output register and one
// item in the write-back stage; req_ready then falls until res_ready returns.
// Configuration must be written only while the block is idle; it is not enforced.
module label_bounding_boxes_top #(
  parameter int MAX_REGIONS = lbb_pkg::MAX_REGIONS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbb_pkg::PADDR_W-1:0] paddr,
  input  logic [lbb_pkg::PDATA_W-1:0] pwdata,
  output logic [lbb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  lbb_pkg::req_t               req_item,
  output logic                        res_valid,
  input  logic                        res_ready,
  output lbb_pkg::res_t               res_item
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int ENTRY_W = $bits(lbb_pkg::entry_t);

  lbb_pkg::cfg_t   cfg;
  lbb_pkg::stage_t stage;
  lbb_pkg::stage_t stage_next;
  lbb_pkg::entry_t old_entry;
  lbb_pkg::entry_t new_entry;
  lbb_pkg::entry_t fwd_entry;
  lbb_pkg::res_t   result;

  logic [ENTRY_W-1:0]      ram_rdata;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [AW-1:0]           ram_waddr;
  logic                    ram_we;
  logic                    accept;
  logic                    stage_valid;
  logic                    stage_go;
  logic [AW-1:0]           stage_addr;
  logic [AW-1:0]           req_addr;
  logic                    fwd_hit;
  logic                    clearing;
  logic [AW-1:0]           clear_addr;
  logic [31:0]             label_wide;
  logic [31:0]             label_limit;
  logic [31:0]             index_wide;
  logic                    label_zero;
  logic                    label_above;
  logic [lbb_pkg::X_W-1:0] pos_x;
  logic [lbb_pkg::Y_W-1:0] pos_y;

  lbb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lbb_pos u_pos (
    .clk           (clk),
    .rst           (rst),
    .advance       (accept && (req_item.mode == lbb_pkg::MODE_PIXEL)),
    .end_of_image  (req_item.end_of_image),
    .column_height (cfg.column_height),
    .x             (pos_x),
    .y             (pos_y)
  );

  assign stage_go = stage_valid && (!res_valid || res_ready);
  assign req_ready = !clearing && (!stage_valid || stage_go);
  assign accept = req_valid && req_ready;

  always_comb begin
    label_wide = 32'(req_item.region_label);
    if (32'(cfg.region_count) < 32'(MAX_REGIONS)) begin
      label_limit = 32'(cfg.region_count);
    end else begin
      label_limit = 32'(MAX_REGIONS);
    end
    index_wide = label_wide - 32'd1;
    req_addr = index_wide[AW-1:0];
    label_zero = (req_item.region_label == '0);
    label_above = (label_wide > label_limit);

    stage_next.mode = req_item.mode;
    stage_next.x = pos_x;
    stage_next.y = pos_y;
    case (req_item.mode)
      lbb_pkg::MODE_READ: begin
        stage_next.label_error = label_zero || label_above;
        stage_next.update = !(label_zero || label_above);
      end
      default: begin
        stage_next.label_error = !label_zero && label_above;
        stage_next.update = !label_zero && !label_above;
      end
    endcase
  end

  assign old_entry = fwd_hit ? fwd_entry : lbb_pkg::entry_t'(ram_rdata);

  lbb_merge u_merge (
    .stage     (stage),
    .old_entry (old_entry),
    .new_entry (new_entry),
    .result    (result)
  );

  assign ram_we = clearing || (stage_go && stage.update);
  assign ram_waddr = clearing ? clear_addr : stage_addr;
  assign ram_wdata = clearing ? '0 : ENTRY_W'(new_entry);

  lbb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_REGIONS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (req_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == AW'(MAX_REGIONS - 1)) begin
        clearing <= 1'b0;
      end
      clear_addr <= clear_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
      fwd_hit <= stage_go && stage.update && (stage_addr == req_addr);
    end else if (stage_go) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
      stage_addr <= req_addr;
      fwd_entry <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stage_go) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      res_item <= result;
    end
  end

endmodule

[design/lbb_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Read data holds while no read is enabled. No dependencies.
module lbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/lbb_cfg.sv]
// Configuration registers of the label bounding box block behind an APB-style port.
// Depends on lbb_pkg.
module lbb_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbb_pkg::PADDR_W-1:0] paddr,
  input  logic [lbb_pkg::PDATA_W-1:0] pwdata,
  output logic [lbb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output lbb_pkg::cfg_t               cfg
);

  logic write_en;

  assign pready = 1'b1;
  assign write_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_height <= lbb_pkg::COLUMN_HEIGHT_RESET;
      cfg.region_count <= lbb_pkg::REGION_COUNT_RESET;
    end else if (write_en) begin
      case (paddr[2])
        lbb_pkg::REG_COLUMN_HEIGHT: cfg.column_height <= pwdata[lbb_pkg::CFG_W-1:0];
        lbb_pkg::REG_REGION_COUNT: cfg.region_count <= pwdata[lbb_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lbb_pkg::REG_COLUMN_HEIGHT: prdata = lbb_pkg::PDATA_W'(cfg.column_height);
      lbb_pkg::REG_REGION_COUNT: prdata = lbb_pkg::PDATA_W'(cfg.region_count);
      default: prdata = '0;
    endcase
  end

endmodule

[design/lbb_pos.sv]
// Row and column position counters for the column-major pixel scan.
// Gives the 1-based position of the current pixel. Depends on lbb_pkg.
module lbb_pos (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          end_of_image,
  input  logic [lbb_pkg::CFG_W-1:0]     column_height,
  output logic [lbb_pkg::X_W-1:0]       x,
  output logic [lbb_pkg::Y_W-1:0]       y
);

  logic [lbb_pkg::ROW_W-1:0] row;
  logic [lbb_pkg::COL_W-1:0] col;
  logic [31:0]               height_limit;
  logic [31:0]               row_inc;
  logic [31:0]               col_inc;

  always_comb begin
    if (column_height == '0) begin
      height_limit = 32'd1;
    end else if (32'(column_height) < 32'(lbb_pkg::MAX_HEIGHT)) begin
      height_limit = 32'(column_height);
    end else begin
      height_limit = 32'(lbb_pkg::MAX_HEIGHT);
    end
    row_inc = 32'(row) + 32'd1;
    col_inc = 32'(col) + 32'd1;
  end

  assign x = lbb_pkg::X_W'(col) + lbb_pkg::X_W'(1);
  assign y = lbb_pkg::Y_W'(row) + lbb_pkg::Y_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (advance) begin
      if (end_of_image) begin
        row <= '0;
        col <= '0;
      end else if (row_inc >= height_limit) begin
        row <= '0;
        if (col_inc >= 32'(lbb_pkg::MAX_WIDTH)) begin
          col <= '0;
        end else begin
          col <= lbb_pkg::COL_W'(col_inc);
        end
      end else begin
        row <= lbb_pkg::ROW_W'(row_inc);
      end
    end
  end

endmodule

[design/lbb_merge.sv]
// Combines one table entry with a pixel position, or reads and clears it.
// Gives the entry to write back and the result item. Depends on lbb_pkg.
module lbb_merge (
  input  lbb_pkg::stage_t stage,
  input  lbb_pkg::entry_t old_entry,
  output lbb_pkg::entry_t new_entry,
  output lbb_pkg::res_t   result
);

  always_comb begin
    new_entry = '0;
    result = '0;
    result.label_error = stage.label_error;
    case (stage.mode)
      lbb_pkg::MODE_READ: begin
        if (stage.update && old_entry.present) begin
          result.present = 1'b1;
          result.x_min = old_entry.x_min;
          result.x_max = old_entry.x_max;
          result.y_min = old_entry.y_min;
          result.y_max = old_entry.y_max;
        end
      end
      lbb_pkg::MODE_PIXEL: begin
        new_entry.present = 1'b1;
        if (!old_entry.present) begin
          new_entry.x_min = stage.x;
          new_entry.x_max = stage.x;
          new_entry.y_min = stage.y;
          new_entry.y_max = stage.y;
        end else begin
          new_entry.x_min = (stage.x < old_entry.x_min) ? stage.x : old_entry.x_min;
          new_entry.x_max = (stage.x > old_entry.x_max) ? stage.x : old_entry.x_max;
          new_entry.y_min = (stage.y < old_entry.y_min) ? stage.y : old_entry.y_min;
          new_entry.y_max = (stage.y > old_entry.y_max) ? stage.y : old_entry.y_max;
        end
      end
      default: ;
    endcase
  end

endmodule

[bench/testbench.sv]
// Self-checking bench for label_bounding_boxes_top: drives label pixels and box reads,
// tracks each region's box in its own table and compares every result item.
// Depends on lbb_pkg and the RTL of the block only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned LONG_HOLD = 400;

  typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_TOGGLE} ready_style_t;

  typedef struct {
    lbb_pkg::req_t req;
    bit            typed;
    lbb_pkg::res_t want;
  } plan_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [lbb_pkg::PADDR_W-1:0] paddr = '0;
  logic [lbb_pkg::PDATA_W-1:0] pwdata = '0;
  logic [lbb_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  lbb_pkg::req_t               req_item = '0;
  logic                        res_valid;
  logic                        res_ready = 1'b0;
  lbb_pkg::res_t               res_item;

  lbb_pkg::entry_t           region_boxes [lbb_pkg::MAX_REGIONS_DEFAULT];
  int unsigned               scan_row = 0;
  int unsigned               scan_col = 0;
  logic [lbb_pkg::CFG_W-1:0] height_reg = lbb_pkg::COLUMN_HEIGHT_RESET;
  logic [lbb_pkg::CFG_W-1:0] count_reg = lbb_pkg::REGION_COUNT_RESET;

  lbb_pkg::res_t boxes_due [$];
  plan_row_t     plan [$];
  int unsigned   fails = 0;
  int unsigned   items_sent = 0;
  int unsigned   work_items = 0;
  int unsigned   results_seen = 0;
  int unsigned   boxes_found = 0;
  int unsigned   errors_flagged = 0;
  int unsigned   settings_used = 0;
  int unsigned   burst_left = 0;
  bit            hold_off_req = 1'b0;

  label_bounding_boxes_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (region_boxes[i]) region_boxes[i] = '0;
  end

  function automatic int unsigned label_cap();
    return (count_reg < lbb_pkg::MAX_REGIONS_DEFAULT) ? count_reg
                                                      : lbb_pkg::MAX_REGIONS_DEFAULT;
  endfunction

  function automatic int unsigned height_cap();
    if (height_reg == 0) begin
      return 1;
    end
    return (height_reg < lbb_pkg::MAX_HEIGHT) ? height_reg : lbb_pkg::MAX_HEIGHT;
  endfunction

  // Advances the tracked table, and for a pixel the scan position, by one item and gives its result.
  function automatic lbb_pkg::res_t next_box_result(input lbb_pkg::req_t r);
    lbb_pkg::res_t o;
    int unsigned   lim;
    int unsigned   idx;
    int unsigned   x;
    int unsigned   y;
    o = '0;
    lim = label_cap();
    idx = (r.region_label == 0) ? 0 : (r.region_label - 1) % lbb_pkg::MAX_REGIONS_DEFAULT;
    if (r.mode == lbb_pkg::MODE_READ) begin
      if (r.region_label == 0 || r.region_label > lim) begin
        o.label_error = 1'b1;
      end else begin
        if (region_boxes[idx].present) begin
          o.present = 1'b1;
          o.x_min = region_boxes[idx].x_min;
          o.x_max = region_boxes[idx].x_max;
          o.y_min = region_boxes[idx].y_min;
          o.y_max = region_boxes[idx].y_max;
        end
        region_boxes[idx] = '0;
      end
      return o;
    end
    if (r.region_label != 0) begin
      if (r.region_label > lim) begin
        o.label_error = 1'b1;
      end else begin
        x = scan_col + 1;
        y = scan_row + 1;
        if (!region_boxes[idx].present) begin
          region_boxes[idx].present = 1'b1;
          region_boxes[idx].x_min = lbb_pkg::X_W'(x);
          region_boxes[idx].x_max = lbb_pkg::X_W'(x);
          region_boxes[idx].y_min = lbb_pkg::Y_W'(y);
          region_boxes[idx].y_max = lbb_pkg::Y_W'(y);
        end else begin
          if (x < region_boxes[idx].x_min) region_boxes[idx].x_min = lbb_pkg::X_W'(x);
          if (x > region_boxes[idx].x_max) region_boxes[idx].x_max = lbb_pkg::X_W'(x);
          if (y < region_boxes[idx].y_min) region_boxes[idx].y_min = lbb_pkg::Y_W'(y);
          if (y > region_boxes[idx].y_max) region_boxes[idx].y_max = lbb_pkg::Y_W'(y);
        end
      end
    end
    if (r.end_of_image) begin
      scan_row = 0;
      scan_col = 0;
    end else begin
      scan_row++;
      if (scan_row >= height_cap()) begin
        scan_row = 0;
        scan_col++;
        if (scan_col >= lbb_pkg::MAX_WIDTH) scan_col = 0;
      end
    end
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_box(input lbb_pkg::res_t got);
    lbb_pkg::res_t want;
    if (boxes_due.size() == 0) begin
      $error("result item arrived with nothing expected");
      fails++;
      return;
    end
    want = boxes_due.pop_front();
    results_seen++;
    if (got.present === 1'b1) boxes_found++;
    if (got.label_error === 1'b1) errors_flagged++;
    check_field("label_error", want.label_error, got.label_error);
    check_field("present", want.present, got.present);
    check_field("x_min", want.x_min, got.x_min);
    check_field("x_max", want.x_max, got.x_max);
    check_field("y_min", want.y_min, got.y_min);
    check_field("y_max", want.y_max, got.y_max);
  endfunction

  task automatic push_item(input lbb_pkg::req_t r, input bit typed, input lbb_pkg::res_t want);
    lbb_pkg::res_t calc;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_item <= r;
    do @(posedge clk); while (!req_ready);
    calc = next_box_result(r);
    boxes_due.push_back(typed ? want : calc);
    items_sent++;
    if (r.mode == lbb_pkg::MODE_READ || r.region_label != 0) work_items++;
  endtask

  task automatic send(input logic mode, input int unsigned label, input bit eoi);
    lbb_pkg::req_t r;
    r.mode = mode;
    r.region_label = lbb_pkg::LABEL_W'(label);
    r.end_of_image = eoi;
    push_item(r, 1'b0, '0);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic sel, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= lbb_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned height, input int unsigned count);
    apb_write(lbb_pkg::REG_COLUMN_HEIGHT, height);
    height_reg = lbb_pkg::CFG_W'(height);
    apb_write(lbb_pkg::REG_REGION_COUNT, count);
    count_reg = lbb_pkg::CFG_W'(count);
    settings_used++;
  endtask

  function automatic lbb_pkg::req_t noise_item(input int unsigned lim);
    lbb_pkg::req_t r;
    r.mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: r.region_label = lbb_pkg::LABEL_W'($urandom_range(0, 2047));
      1: r.region_label = lbb_pkg::LABEL_W'(lim + 1);
      2: r.region_label = lbb_pkg::LABEL_W'(lim);
      default: r.region_label = lbb_pkg::LABEL_W'($urandom_range(0, (lim < 8) ? lim : 8));
    endcase
    r.end_of_image = ($urandom_range(0, 15) == 0);
    return r;
  endfunction

  // One whole image of the given number of columns, then a read of every valid label used.
  task automatic run_image(input int unsigned hgt, input int unsigned lim,
                           input int unsigned cols);
    int unsigned n_lab;
    int unsigned total;
    int unsigned label;
    n_lab = (lim < 6) ? lim : 6;
    total = cols * hgt;
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        label = $urandom_range(lim + 1, 2047);
      end else begin
        label = $urandom_range(0, n_lab);
      end
      send(lbb_pkg::MODE_PIXEL, label, i == total - 1);
    end
    for (int k = 1; k <= n_lab; k++) begin
      send(lbb_pkg::MODE_READ, k, $urandom_range(0, 9) == 0);
    end
    if ($urandom_range(0, 3) == 0) begin
      send(lbb_pkg::MODE_READ,
           ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(lim + 1, 2047), 1'b0);
    end
  endtask

  task automatic random_mix(input int unsigned n);
    int unsigned goal;
    int unsigned room;
    int unsigned hgt;
    int unsigned lim;
    int unsigned cols;
    goal = items_sent + n;
    hgt = height_cap();
    lim = label_cap();
    while (items_sent < goal) begin
      room = goal - items_sent;
      if (hgt <= 64 && room > hgt && $urandom_range(0, 4) != 0) begin
        cols = ($urandom_range(0, 7) == 0) ? $urandom_range(1, (400 / hgt > 1) ? 400 / hgt : 1)
                                           : $urandom_range(1, 5);
        if (cols * hgt > room) cols = room / hgt;
        run_image(hgt, lim, cols);
      end else begin
        repeat ($urandom_range(1, (room < 10) ? room : 10)) begin
          push_item(noise_item(lim), 1'b0, '0);
        end
      end
    end
    settle();
  endtask

  function automatic void add_row(input logic mode, input int unsigned label, input bit eoi,
                                  input bit typed, input bit err, input bit pres,
                                  input int unsigned xmin, input int unsigned xmax,
                                  input int unsigned ymin, input int unsigned ymax);
    plan_row_t row;
    row.req.mode = mode;
    row.req.region_label = lbb_pkg::LABEL_W'(label);
    row.req.end_of_image = eoi;
    row.typed = typed;
    row.want.label_error = err;
    row.want.present = pres;
    row.want.x_min = lbb_pkg::X_W'(xmin);
    row.want.x_max = lbb_pkg::X_W'(xmax);
    row.want.y_min = lbb_pkg::Y_W'(ymin);
    row.want.y_max = lbb_pkg::Y_W'(ymax);
    plan.push_back(row);
  endfunction

  initial begin : result_side
    ready_style_t style;
    int unsigned  style_left;
    int unsigned  hold_left;
    style = READY_ALWAYS;
    style_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (res_valid && res_ready) check_box(res_item);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style = ready_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        case (style)
          READY_ALWAYS: res_ready <= 1'b1;
          READY_HALF: res_ready <= 1'($urandom_range(0, 1));
          READY_SPARSE: res_ready <= ($urandom_range(0, 4) == 0);
          default: res_ready <= ~res_ready;
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) break;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_row(lbb_pkg::MODE_READ, 1, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_READ, 0, 0, 1, 1, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_READ, 2047, 0, 1, 1, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_READ, 1025, 0, 1, 1, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_READ, 1024, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 2047, 0, 1, 1, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 1025, 1, 1, 1, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 1024, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 1024, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 7, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_READ, 1024, 0, 1, 0, 1, 1, 1, 1, 2);
    add_row(lbb_pkg::MODE_READ, 1024, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_READ, 7, 1, 1, 0, 1, 1, 1, 3, 3);
    add_row(lbb_pkg::MODE_PIXEL, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 2, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_READ, 3, 0, 1, 0, 1, 1, 1, 1, 3);
    add_row(lbb_pkg::MODE_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_PIXEL, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(lbb_pkg::MODE_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    foreach (plan[i]) push_item(plan[i].req, plan[i].typed, plan[i].want);
    settle();

    // The receiver holds off for a long stretch here, so the block fills and stalls.
    set_regs(4, 16);
    hold_off_req = 1'b1;
    random_mix(250);

    set_regs(0, 1024);
    random_mix(120);

    set_regs(2047, 2047);
    run_image(height_cap(), label_cap(), 1);
    random_mix(40);

    // A tall column part-scanned, then the height shrinks below the current row.
    set_regs(1024, 8);
    repeat (60) send(lbb_pkg::MODE_PIXEL, $urandom_range(0, 8), 1'b0);
    settle();
    set_regs(5, 8);
    repeat (20) send(lbb_pkg::MODE_PIXEL, $urandom_range(0, 8), 1'b0);
    for (int k = 1; k <= 8; k++) send(lbb_pkg::MODE_READ, k, 1'b0);
    settle();

    set_regs(7, 0);
    random_mix(50);
    set_regs(3, 1);
    random_mix(50);
    repeat (6) begin
      set_regs($urandom_range(1, 16),
               ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(1, 40));
      random_mix(25);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Sent %0d items (%0d reads or labelled pixels) over %0d register settings.",
             items_sent, work_items, settings_used);
    $display("Checked %0d results: %0d boxes present, %0d label errors.",
             results_seen, boxes_found, errors_flagged);
    if (fails == 0 && boxes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
